[rtl/csmcp_pkg.sv]
// csmcp_pkg: shared types and codes for the size-map configuration parser.
// Used by csmcp_parse, csmcp_emit and csi2_size_map_config_parser.
package csmcp_pkg;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned INDEX_W  = 11;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned MAPNUM_W = 3;
    localparam int unsigned SIZE_W   = 12;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned MCOUNT_W = 4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DESC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    // Status codes, in check order
    localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT_COUNT = 4'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC_NPAR  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC_WIDTH = 4'd4;
    localparam logic [STATUS_W-1:0] ST_SIGMA_BIG   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 4'd6;
    localparam logic [STATUS_W-1:0] ST_TRUNC_DATA  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TRAILING    = 4'd8;

    // sigma at or above this is rejected outright
    localparam logic [15:0] SIGMA_LIMIT = 16'd64;

    typedef enum logic [2:0] {
        PH_CNT_LO,
        PH_CNT_HI,
        PH_NPARAM,
        PH_WIDTHS,
        PH_ENT_LO,
        PH_ENT_HI,
        PH_DONE,
        PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_DESC,
        SQ_STATUS
    } t_seq;

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } t_entry_wr;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
    } t_end_ev;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [INDEX_W-1:0]  entry_index;
        logic [VALUE_W-1:0]  entry_value;
        logic [MAPNUM_W-1:0] map_number;
        logic [INDEX_W-1:0]  map_start;
        logic [SIZE_W-1:0]   map_size;
        logic [STATUS_W-1:0] status;
        logic [MCOUNT_W-1:0] map_count;
        logic                last_of_run;
    } t_result;

endpackage

[rtl/csmcp_parse.sv]
// csmcp_parse: byte-level parse state, error latch and map bookkeeping.
// Produces entry writes, descriptor store writes and the end-of-payload event.
// Depends on csmcp_pkg.
module csmcp_parse #(
    parameter int unsigned MAX_MAPS    = 8,
    parameter int unsigned MAP_ENTRIES = 2048,
    parameter int unsigned CW          = $clog2(MAX_MAPS + 1),
    parameter int unsigned AW          = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1,
    parameter int unsigned NW          = $clog2(MAP_ENTRIES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_payload_byte,
    input  logic                  i_has_byte,
    input  logic                  i_last,
    output csmcp_pkg::t_entry_wr  o_entry_wr,
    output logic                  o_desc_we,
    output logic [AW-1:0]         o_desc_addr,
    output logic [2*NW-1:0]       o_desc_data,
    output csmcp_pkg::t_end_ev    o_end,
    output logic [CW-1:0]         o_end_total
);
    import csmcp_pkg::*;

    localparam int unsigned LOG_M = NW - 1;     // floor(log2(MAP_ENTRIES))
    localparam int unsigned SW    = $clog2(NW);
    localparam logic [NW:0] LIMIT = (NW + 1)'(MAP_ENTRIES);

    t_phase          r_phase, n_phase;
    logic [7:0]      r_cnt_lo, n_cnt_lo;
    logic [CW-1:0]   r_map_total, n_map_total;
    logic [CW-1:0]   r_maps_done, n_maps_done;
    logic [7:0]      r_params, n_params;
    logic [15:0]     r_sigma, n_sigma;
    logic [NW-1:0]   r_ent_left, n_ent_left;
    logic [7:0]      r_ent_lo, n_ent_lo;
    logic [NW-1:0]   r_next_start, n_next_start;
    logic [STATUS_W-1:0] r_err, n_err;

    logic [15:0]         cnt16;
    logic [15:0]         close_sigma;
    logic                close_big;
    logic                close_room;
    logic [NW-1:0]       close_size;
    logic [NW:0]         close_end;
    logic                do_close;
    logic [STATUS_W-1:0] byte_fail;
    logic [STATUS_W-1:0] end_code;
    logic [CW-1:0]       done_inc;

    assign cnt16       = {i_payload_byte, r_cnt_lo};
    assign close_sigma = (r_phase == PH_NPARAM) ? 16'd0 : r_sigma + 16'(i_payload_byte);
    assign close_big   = (close_sigma > 16'(LOG_M));
    assign close_size  = NW'(1) << close_sigma[SW-1:0];
    assign close_end   = {1'b0, r_next_start} + {1'b0, close_size};
    assign close_room  = !close_big && (close_end <= LIMIT);
    assign done_inc    = r_maps_done + CW'(1);

    always_comb begin
        n_phase      = r_phase;
        n_cnt_lo     = r_cnt_lo;
        n_map_total  = r_map_total;
        n_maps_done  = r_maps_done;
        n_params     = r_params;
        n_sigma      = r_sigma;
        n_ent_left   = r_ent_left;
        n_ent_lo     = r_ent_lo;
        n_next_start = r_next_start;
        n_err        = r_err;
        do_close     = 1'b0;
        byte_fail    = ST_OK;
        end_code     = ST_OK;
        o_entry_wr   = '0;
        o_desc_we    = 1'b0;
        o_desc_addr  = r_maps_done[AW-1:0];
        o_desc_data  = {close_size, r_next_start};
        o_end        = '0;
        o_end_total  = '0;

        if (i_accept && i_has_byte) begin
            unique case (r_phase)
                PH_CNT_LO: begin
                    n_cnt_lo = i_payload_byte;
                    n_phase  = PH_CNT_HI;
                end
                PH_CNT_HI: begin
                    if (cnt16 > 16'(MAX_MAPS)) begin
                        byte_fail = ST_TOO_MANY;
                    end else begin
                        n_map_total = CW'(cnt16);
                        n_maps_done = '0;
                        n_phase     = (cnt16 == 16'd0) ? PH_DONE : PH_NPARAM;
                    end
                end
                PH_NPARAM: begin
                    n_params = i_payload_byte;
                    n_sigma  = 16'd0;
                    if (i_payload_byte == 8'd0) begin
                        do_close = 1'b1;
                    end else begin
                        n_phase = PH_WIDTHS;
                    end
                end
                PH_WIDTHS: begin
                    n_sigma  = close_sigma;
                    n_params = r_params - 8'd1;
                    if (r_params == 8'd1) begin
                        do_close = 1'b1;
                    end
                end
                PH_ENT_LO: begin
                    n_ent_lo = i_payload_byte;
                    n_phase  = PH_ENT_HI;
                end
                PH_ENT_HI: begin
                    o_entry_wr.valid = 1'b1;
                    o_entry_wr.index = INDEX_W'(r_next_start);
                    o_entry_wr.value = {i_payload_byte, r_ent_lo};
                    n_next_start     = r_next_start + NW'(1);
                    n_ent_left       = r_ent_left - NW'(1);
                    if (r_ent_left <= NW'(1)) begin
                        n_maps_done = done_inc;
                        n_phase     = (done_inc >= r_map_total) ? PH_DONE : PH_NPARAM;
                    end else begin
                        n_phase = PH_ENT_LO;
                    end
                end
                PH_DONE: begin
                    byte_fail = ST_TRAILING;
                end
                PH_DRAIN: begin
                end
                default: begin
                end
            endcase

            // all widths of a map are in: check sigma and room, then accept it
            if (do_close) begin
                if (close_sigma >= SIGMA_LIMIT) begin
                    byte_fail = ST_SIGMA_BIG;
                end else if (!close_room) begin
                    byte_fail = ST_OVERFLOW;
                end else begin
                    o_desc_we  = 1'b1;
                    n_ent_left = close_size;
                    n_phase    = PH_ENT_LO;
                end
            end

            if (byte_fail != ST_OK) begin
                if (r_err == ST_OK) begin
                    n_err = byte_fail;
                end
                n_phase = PH_DRAIN;
            end
        end

        if (i_accept && i_last) begin
            end_code = n_err;
            if (n_err == ST_OK) begin
                unique case (n_phase)
                    PH_CNT_LO, PH_CNT_HI: end_code = ST_SHORT_COUNT;
                    PH_NPARAM:            end_code = ST_TRUNC_NPAR;
                    PH_WIDTHS:            end_code = ST_TRUNC_WIDTH;
                    PH_ENT_LO, PH_ENT_HI: end_code = ST_TRUNC_DATA;
                    default:              end_code = ST_OK;
                endcase
            end
            o_end.valid  = 1'b1;
            o_end.status = end_code;
            o_end_total  = n_map_total;
            // back to the reset state for the next payload
            n_phase      = PH_CNT_LO;
            n_cnt_lo     = '0;
            n_map_total  = '0;
            n_maps_done  = '0;
            n_params     = '0;
            n_sigma      = '0;
            n_ent_left   = '0;
            n_ent_lo     = '0;
            n_next_start = '0;
            n_err        = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CNT_LO;
            r_cnt_lo     <= '0;
            r_map_total  <= '0;
            r_maps_done  <= '0;
            r_params     <= '0;
            r_sigma      <= '0;
            r_ent_left   <= '0;
            r_ent_lo     <= '0;
            r_next_start <= '0;
            r_err        <= ST_OK;
        end else begin
            r_phase      <= n_phase;
            r_cnt_lo     <= n_cnt_lo;
            r_map_total  <= n_map_total;
            r_maps_done  <= n_maps_done;
            r_params     <= n_params;
            r_sigma      <= n_sigma;
            r_ent_left   <= n_ent_left;
            r_ent_lo     <= n_ent_lo;
            r_next_start <= n_next_start;
            r_err        <= n_err;
        end
    end

    a_start_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_next_start} <= LIMIT))
        else $error("next store index beyond map store");

    a_done_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_maps_done <= r_map_total))
        else $error("more maps completed than announced");

endmodule

[rtl/csmcp_emit.sv]
// csmcp_emit: descriptor store (sync RAM), end-of-payload sequencer and
// two-entry output queue. Depends on csmcp_pkg.
module csmcp_emit #(
    parameter int unsigned MAX_MAPS    = 8,
    parameter int unsigned MAP_ENTRIES = 2048,
    parameter int unsigned CW          = $clog2(MAX_MAPS + 1),
    parameter int unsigned AW          = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1,
    parameter int unsigned NW          = $clog2(MAP_ENTRIES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csmcp_pkg::t_entry_wr  i_entry_wr,
    input  logic                  i_desc_we,
    input  logic [AW-1:0]         i_desc_addr,
    input  logic [2*NW-1:0]       i_desc_data,
    input  csmcp_pkg::t_end_ev    i_end,
    input  logic [CW-1:0]         i_end_total,
    input  logic                  i_out_stall,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output csmcp_pkg::t_result    o_result
);
    import csmcp_pkg::*;

    // descriptor store: {size, start} per map
    logic [2*NW-1:0] r_mem [MAX_MAPS];
    logic [2*NW-1:0] r_rdata;
    logic [AW-1:0]   rd_addr;

    t_seq                r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_total, n_total;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0]       idx_inc;

    t_result     r_fifo [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_count;
    logic        pop, room, push, seq_push;
    t_result     push_data, seq_data;

    assign pop     = o_out_valid && !i_out_stall;
    assign room    = (r_count != 2'd2) || pop;
    assign push    = i_entry_wr.valid || seq_push;
    assign idx_inc = r_idx + CW'(1);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_total  = r_total;
        n_status = r_status;
        seq_push = 1'b0;
        seq_data = '0;
        rd_addr  = '0;
        unique case (r_state)
            SQ_IDLE: begin
                if (i_end.valid) begin
                    n_idx    = '0;
                    n_total  = i_end_total;
                    n_status = i_end.status;
                    n_state  = (i_end.status == ST_OK && i_end_total != '0) ?
                               SQ_DESC : SQ_STATUS;
                end
            end
            SQ_DESC: begin
                rd_addr             = r_idx[AW-1:0];
                seq_push            = room;
                seq_data.kind       = KIND_DESC;
                seq_data.map_number = MAPNUM_W'(r_idx);
                seq_data.map_start  = INDEX_W'(r_rdata[NW-1:0]);
                seq_data.map_size   = SIZE_W'(r_rdata[2*NW-1:NW]);
                if (room) begin
                    if (idx_inc == r_total) begin
                        n_state = SQ_STATUS;
                    end else begin
                        n_idx   = idx_inc;
                        rd_addr = idx_inc[AW-1:0];
                    end
                end
            end
            SQ_STATUS: begin
                seq_push             = room;
                seq_data.kind        = KIND_STATUS;
                seq_data.status      = r_status;
                seq_data.map_count   = (r_status == ST_OK) ? MCOUNT_W'(r_total) : '0;
                seq_data.last_of_run = 1'b1;
                if (room) begin
                    n_state = SQ_IDLE;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_comb begin
        push_data = seq_data;
        if (i_entry_wr.valid) begin
            push_data             = '0;
            push_data.kind        = KIND_ENTRY;
            push_data.entry_index = i_entry_wr.index;
            push_data.entry_value = i_entry_wr.value;
        end
    end

    // input is held off while the end-of-payload burst runs
    assign o_in_stall  = (r_state != SQ_IDLE) || (r_count == 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_result    = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_desc_we) begin
            r_mem[i_desc_addr] <= i_desc_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SQ_IDLE;
            r_idx    <= '0;
            r_total  <= '0;
            r_status <= ST_OK;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_total  <= n_total;
            r_status <= n_status;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    a_no_entry_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != SQ_IDLE) |-> !i_entry_wr.valid)
        else $error("entry write arrived during descriptor burst");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> ((r_count != 2'd2) || pop))
        else $error("output queue overflow");

    a_end_starts_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_end.valid |=> (r_state != SQ_IDLE))
        else $error("end of payload did not start the sequencer");

endmodule

[rtl/csi2_size_map_config_parser.sv]
// csi2_size_map_config_parser: top level of the size-map configuration parser.
// Instantiates csmcp_parse and csmcp_emit; depends on csmcp_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_stall): one item per unstalled cycle, each
//   carrying an optional payload byte (i_has_byte) and an end marker (i_last). An
//   item with neither does nothing. Output channel (o_out_valid / i_out_stall):
//   entry writes, map descriptors and one final status item per payload.
//   An entry write enters the output queue in the cycle its high byte is taken.
//   One byte per cycle unless stalled; per-byte work is a small add and compare.
//   End of payload: the item with i_last stalls the input while the sequencer
//   reads the descriptor store, one map per cycle while the output queue has
//   room, then sends the status item; on error only the status item is sent.
//   Output: a two-entry queue decouples the sides, so input keeps flowing while
//   one result waits; outside the end-of-payload burst the input stalls only
//   when that queue is full.
//   Entry writes are provisional: they count only if the status is success.
//   Reset: synchronous, active low; clears parse state, sequencer and queue.
//   The descriptor store is not cleared; each map's entry is written before
//   it is read in the same payload.
module csi2_size_map_config_parser #(
    parameter int unsigned MAX_MAPS    = 8,
    parameter int unsigned MAP_ENTRIES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [10:0] o_entry_index,
    output logic [15:0] o_entry_value,
    output logic [2:0]  o_map_number,
    output logic [10:0] o_map_start,
    output logic [11:0] o_map_size,
    output logic [3:0]  o_status,
    output logic [3:0]  o_map_count,
    output logic        o_last_of_run
);
    import csmcp_pkg::*;

    localparam int unsigned CW = $clog2(MAX_MAPS + 1);
    localparam int unsigned AW = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
    localparam int unsigned NW = $clog2(MAP_ENTRIES + 1);

    logic            in_accept;
    t_entry_wr       entry_wr;
    logic            desc_we;
    logic [AW-1:0]   desc_addr;
    logic [2*NW-1:0] desc_data;
    t_end_ev         end_ev;
    logic [CW-1:0]   end_total;
    t_result         result;

    assign in_accept = i_in_valid && !o_in_stall;

    csmcp_parse #(
        .MAX_MAPS    (MAX_MAPS),
        .MAP_ENTRIES (MAP_ENTRIES),
        .CW          (CW),
        .AW          (AW),
        .NW          (NW)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_payload_byte (i_payload_byte),
        .i_has_byte     (i_has_byte),
        .i_last         (i_last),
        .o_entry_wr     (entry_wr),
        .o_desc_we      (desc_we),
        .o_desc_addr    (desc_addr),
        .o_desc_data    (desc_data),
        .o_end          (end_ev),
        .o_end_total    (end_total)
    );

    csmcp_emit #(
        .MAX_MAPS    (MAX_MAPS),
        .MAP_ENTRIES (MAP_ENTRIES),
        .CW          (CW),
        .AW          (AW),
        .NW          (NW)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry_wr  (entry_wr),
        .i_desc_we   (desc_we),
        .i_desc_addr (desc_addr),
        .i_desc_data (desc_data),
        .i_end       (end_ev),
        .i_end_total (end_total),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_kind        = result.kind;
    assign o_entry_index = result.entry_index;
    assign o_entry_value = result.entry_value;
    assign o_map_number  = result.map_number;
    assign o_map_start   = result.map_start;
    assign o_map_size    = result.map_size;
    assign o_status      = result.status;
    assign o_map_count   = result.map_count;
    assign o_last_of_run = result.last_of_run;

endmodule
